@@ hw/rtl/deq_pkg.sv @@
// Shared types and codes for the double-ended queue engine.
// Request and result payload structs, request and status codes, default capacity.
// No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

  // Default ring depth
  localparam int CAPACITY_DEF = 64;

  // Field widths
  localparam int REQ_W  = 3;
  localparam int VAL_W  = 32;
  localparam int STEP_W = 31;
  localparam int DROP_W = 16;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int FILL_W = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ADD_FRONT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_BACK   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DROP_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DROP_BACK  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_GET        = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTIED = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

  typedef struct packed {
    logic        [REQ_W-1:0]  req_type;
    logic signed [VAL_W-1:0]  run_start;
    logic        [STEP_W-1:0] run_step;
    logic signed [VAL_W-1:0]  run_end;
    logic        [DROP_W-1:0] drop_count;
    logic        [POS_W-1:0]  position;
  } deq_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  element_value;
    logic        [STAT_W-1:0] status;
    logic        [FILL_W-1:0] fill_level;
    logic                     carries_element;
    logic                     last_of_run;
  } deq_res_t;

endpackage

@@ hw/rtl/deq_store.sv @@
// Ring store of the queue: one write port, one read port, registered read data.
// Read data holds its value until the next read is issued.
// Depends on deq_pkg for the value width.
`timescale 1ns / 1ps

module deq_store #(
  parameter int DEPTH  = deq_pkg::CAPACITY_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [deq_pkg::VAL_W-1:0]     wr_data,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [deq_pkg::VAL_W-1:0]     rd_data
);

  logic [deq_pkg::VAL_W-1:0] mem [DEPTH];
  logic [deq_pkg::VAL_W-1:0] rd_data_r;

  // Write the entry, and read into the output register on request
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/double_ended_queue_engine.sv @@
// Top level of the double-ended queue engine: request sequencer, pointers, result register.
// Depends on deq_pkg (types, codes) and deq_store (ring memory).
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------------
//   in      | in_valid, in_ready, in_data    | one request (deq_req_t)
//   out     | out_valid, out_ready, out_data | one or more results (deq_res_t)
//
// Steps: a push run writes its values in S_RUN, then loads its result in S_RESULT;
// removals, gets and other codes go to S_RESULT; an output-all walks S_STREAM.
// The single write and read ports of the ring store set the one-element-per-cycle walk.
// One request is in work at a time; in_ready is high while the sequencer is idle.
// A result waits in the output register while out_ready is low and the walk stalls.
// Reset clears pointers and fill count; the store itself is not cleared.
`timescale 1ns / 1ps

module double_ended_queue_engine #(
  parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::deq_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output deq_pkg::deq_res_t out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_RESULT,
    S_STREAM
  } state_t;

  state_t                           state_r, state_nxt;
  logic [IDX_W-1:0]                 front_r, front_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic signed [deq_pkg::VAL_W:0]   v_r, v_nxt;
  logic signed [deq_pkg::VAL_W-1:0] end_r, end_nxt;
  logic [deq_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic                             add_front_r, add_front_nxt;
  logic [deq_pkg::STAT_W-1:0]       status_r, status_nxt;
  logic                             carry_r, carry_nxt;
  logic [IDX_W-1:0]                 idx_r, idx_nxt;
  logic [IDX_W-1:0]                 slot_r, slot_nxt;
  logic                             out_valid_r, out_valid_nxt;
  deq_pkg::deq_res_t                out_r, out_nxt;

  logic                             wr_en;
  logic [IDX_W-1:0]                 wr_addr;
  logic [deq_pkg::VAL_W-1:0]        wr_data;
  logic                             rd_en;
  logic [IDX_W-1:0]                 rd_addr;
  logic [deq_pkg::VAL_W-1:0]        rd_data;

  logic                             in_acc;
  logic                             out_free;
  logic                             full;
  logic                             run_over;
  logic                             pos_bad;
  logic                             drop_over;
  logic [CNT_W-1:0]                 drop_n;
  logic [IDX_W-1:0]                 front_dec;
  logic [IDX_W-1:0]                 back_slot;
  logic [IDX_W-1:0]                 get_slot;
  logic [IDX_W-1:0]                 drop_front;
  logic [IDX_W-1:0]                 slot_inc;
  logic                             stream_last;

  // Ring index of base plus offset, offset at most CAPACITY
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] ofs);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(ofs);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  deq_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  // Pointer arithmetic around the ring
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign run_over    = v_r > $signed({end_r[deq_pkg::VAL_W-1], end_r});
  assign pos_bad     = {1'b0, in_data.position} >= deq_pkg::FILL_W'(count_r);
  assign drop_over   = in_data.drop_count > deq_pkg::DROP_W'(count_r);
  assign drop_n      = drop_over ? count_r : CNT_W'(in_data.drop_count);
  assign front_dec   = (front_r == '0) ? IDX_W'(CAPACITY - 1) : front_r - 1'b1;
  assign back_slot   = ring_add(front_r, count_r);
  assign get_slot    = ring_add(front_r, CNT_W'(in_data.position));
  assign drop_front  = ring_add(front_r, drop_n);
  assign slot_inc    = (slot_r == IDX_W'(CAPACITY - 1)) ? '0 : slot_r + 1'b1;
  assign stream_last = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  // Sequence requests: decode, walk runs and streams, load results
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    v_nxt         = v_r;
    end_nxt       = end_r;
    step_nxt      = step_r;
    add_front_nxt = add_front_r;
    status_nxt    = status_r;
    carry_nxt     = carry_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = back_slot;
    wr_data       = v_r[deq_pkg::VAL_W-1:0];
    rd_en         = 1'b0;
    rd_addr       = slot_inc;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          status_nxt = deq_pkg::ST_OK;
          carry_nxt  = 1'b0;
          state_nxt  = S_RESULT;
          case (in_data.req_type)
            deq_pkg::REQ_ADD_FRONT, deq_pkg::REQ_ADD_BACK: begin
              v_nxt         = $signed({in_data.run_start[deq_pkg::VAL_W-1],
                                       in_data.run_start});
              end_nxt       = in_data.run_end;
              step_nxt      = in_data.run_step;
              add_front_nxt = (in_data.req_type == deq_pkg::REQ_ADD_FRONT);
              state_nxt     = S_RUN;
            end
            deq_pkg::REQ_DROP_FRONT, deq_pkg::REQ_DROP_BACK: begin
              count_nxt = count_r - drop_n;
              if (in_data.req_type == deq_pkg::REQ_DROP_FRONT) begin
                front_nxt = drop_front;
              end
              status_nxt = drop_over ? deq_pkg::ST_EMPTIED : deq_pkg::ST_OK;
            end
            deq_pkg::REQ_GET: begin
              if (pos_bad) begin
                status_nxt = deq_pkg::ST_RANGE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = get_slot;
                carry_nxt = 1'b1;
              end
            end
            deq_pkg::REQ_DUMP: begin
              if (count_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                slot_nxt  = front_r;
                idx_nxt   = '0;
                state_nxt = S_STREAM;
              end
            end
            default: begin
              status_nxt = deq_pkg::ST_OK;
            end
          endcase
        end
      end

      // Push one run value per cycle, stop at the bound or at capacity
      S_RUN: begin
        if (run_over) begin
          status_nxt = deq_pkg::ST_OK;
          state_nxt  = S_RESULT;
        end else if (full) begin
          status_nxt = deq_pkg::ST_FULL;
          state_nxt  = S_RESULT;
        end else begin
          wr_en = 1'b1;
          if (add_front_r) begin
            wr_addr   = front_dec;
            front_nxt = front_dec;
          end
          count_nxt = count_r + 1'b1;
          v_nxt     = v_r + $signed({2'b00, step_r});
        end
      end

      // Hand over the single result once the output register is free
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_nxt.element_value   = carry_r ? $signed(rd_data) : '0;
          out_nxt.status          = status_r;
          out_nxt.fill_level      = deq_pkg::FILL_W'(count_r);
          out_nxt.carries_element = carry_r;
          out_nxt.last_of_run     = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      // Stream elements front to back; hold the read data while stalled
      S_STREAM: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_nxt.element_value   = $signed(rd_data);
          out_nxt.status          = deq_pkg::ST_OK;
          out_nxt.fill_level      = deq_pkg::FILL_W'(count_r);
          out_nxt.carries_element = 1'b1;
          out_nxt.last_of_run     = stream_last;
          if (stream_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = slot_inc;
            slot_nxt = slot_inc;
            idx_nxt  = idx_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, pointers and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers need no reset
  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    end_r       <= end_nxt;
    step_r      <= step_nxt;
    add_front_r <= add_front_nxt;
    status_r    <= status_nxt;
    carry_r     <= carry_nxt;
    idx_r       <= idx_nxt;
    slot_r      <= slot_nxt;
    out_r       <= out_nxt;
  end

  // Fill count never passes the ring depth, front pointer stays inside the ring
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(CAPACITY)) && (SUM_W'(front_r) < SUM_W'(CAPACITY)))
    else $error("fill count or front pointer out of range");

  // A store write only happens during a run with room left
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_RUN) && !full)
    else $error("store written without room");

  // Fill count moves only during a run or on an accepted request
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RUN) && !in_acc |=> $stable(count_r))
    else $error("fill count changed while idle or streaming");

  // A result with a stored element always reports ok
  a_elem_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.carries_element |-> out_data.status == deq_pkg::ST_OK)
    else $error("element result with non-ok status");

  // A new result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_r))
    else $error("waiting result overwritten");

endmodule

@@ verif/deq_checker.sv @@
// Request predictor and result scoreboard for the double-ended queue engine.
// Watches both channels, keeps its own copy of the ring, compares every result.
// Depends on deq_pkg for payload types and request/status codes.
`timescale 1ns / 1ps

module deq_checker #(
  parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  deq_pkg::deq_req_t in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  deq_pkg::deq_res_t out_data,
  output int                fail_count,
  output int                pending,
  output int                requests_seen,
  output int                results_seen
);

  // Shadow of the ring and its pointers
  logic [deq_pkg::VAL_W-1:0] ring_copy [CAPACITY];
  int                        head;
  int                        held;
  deq_pkg::deq_res_t         due_results [$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    requests_seen = 0;
    results_seen  = 0;
    head          = 0;
    held          = 0;
  end

  // Queue one expected result; fill level is taken after the request's effect
  task automatic queue_result(logic [deq_pkg::VAL_W-1:0] value,
                              logic [deq_pkg::STAT_W-1:0] st,
                              logic carries, logic last);
    deq_pkg::deq_res_t res;
    res.element_value   = value;
    res.status          = st;
    res.fill_level      = held[deq_pkg::FILL_W-1:0];
    res.carries_element = carries;
    res.last_of_run     = last;
    due_results.insert(due_results.size(), res);
  endtask

  // Apply one accepted request to the shadow ring and queue what it yields
  task automatic predict_request(deq_pkg::deq_req_t r);
    longint                     v;
    longint                     stride;
    longint                     stop;
    int                         n;
    logic [deq_pkg::STAT_W-1:0] st;
    st = deq_pkg::ST_OK;
    case (r.req_type)
      deq_pkg::REQ_ADD_FRONT, deq_pkg::REQ_ADD_BACK: begin
        v      = longint'(r.run_start);
        stride = longint'({1'b0, r.run_step});
        stop   = longint'(r.run_end);
        while (v <= stop) begin
          if (held >= CAPACITY) begin
            st = deq_pkg::ST_FULL;
            break;
          end
          if (r.req_type == deq_pkg::REQ_ADD_FRONT) begin
            head = (head + CAPACITY - 1) % CAPACITY;
            ring_copy[head] = v[deq_pkg::VAL_W-1:0];
          end else begin
            ring_copy[(head + held) % CAPACITY] = v[deq_pkg::VAL_W-1:0];
          end
          held++;
          v += stride;
        end
        queue_result('0, st, 1'b0, 1'b1);
      end
      deq_pkg::REQ_DROP_FRONT, deq_pkg::REQ_DROP_BACK: begin
        n = int'(r.drop_count);
        if (n > held) begin
          n  = held;
          st = deq_pkg::ST_EMPTIED;
        end
        if (r.req_type == deq_pkg::REQ_DROP_FRONT) head = (head + n) % CAPACITY;
        held -= n;
        queue_result('0, st, 1'b0, 1'b1);
      end
      deq_pkg::REQ_GET: begin
        if (int'(r.position) >= held)
          queue_result('0, deq_pkg::ST_RANGE, 1'b0, 1'b1);
        else
          queue_result(ring_copy[(head + int'(r.position)) % CAPACITY], deq_pkg::ST_OK,
                       1'b1, 1'b1);
      end
      deq_pkg::REQ_DUMP: begin
        if (held == 0) begin
          queue_result('0, deq_pkg::ST_OK, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < held; i++)
            queue_result(ring_copy[(head + i) % CAPACITY], deq_pkg::ST_OK, 1'b1,
                         i == held - 1);
        end
      end
      // Spare codes leave the ring alone
      default: queue_result('0, deq_pkg::ST_OK, 1'b0, 1'b1);
    endcase
  endtask

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Compare one result against the oldest expectation
  task automatic compare_result(deq_pkg::deq_res_t got);
    deq_pkg::deq_res_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none, got value %0d status %0d fill %0d",
               $time, got.element_value, got.status, got.fill_level);
      return;
    end
    want = due_results.pop_front();
    check_field("element_value", want.element_value, got.element_value);
    check_field("status", want.status, got.status);
    check_field("fill_level", want.fill_level, got.fill_level);
    check_field("carries_element", want.carries_element, got.carries_element);
    check_field("last_of_run", want.last_of_run, got.last_of_run);
  endtask

  // Results first, then the new request: a request cannot answer on its own edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) compare_result(out_data);
      if (in_valid && in_ready) begin
        requests_seen++;
        predict_request(in_data);
      end
    end
    pending <= due_results.size();
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the double-ended queue engine: clock, reset, request stimulus,
// random result back-pressure and the final verdict.
// Depends on deq_pkg, double_ended_queue_engine and deq_checker.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_REQUESTS = 460;

  // Codes the block has no meaning for
  localparam logic [deq_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [deq_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam longint VAL_MAX = (longint'(1) <<< 31) - 1;
  localparam longint VAL_MIN = -(longint'(1) <<< 31);

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  deq_pkg::deq_req_t in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  deq_pkg::deq_res_t out_data;

  int fail_count;
  int pending;
  int requests_seen;
  int results_seen;

  int send_calm  = 0;
  int ready_calm = 0;
  int ready_hold = 0;

  deq_pkg::deq_req_t directed_reqs [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_queue_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  deq_checker CHK (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .requests_seen (requests_seen),
    .results_seen  (results_seen)
  );

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  // Sender gap with occasional back-to-back stretches
  function int sender_gap();
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(15, 50);
    return ($urandom_range(0, 1) == 0) ? 0 : pick_gap();
  endfunction

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (ready_calm > 0) ready_calm--;
      else if ($urandom_range(0, 99) < 3) ready_calm = $urandom_range(20, 80);
      else if ($urandom_range(0, 3) == 0) ready_hold = pick_gap();
    end
  end

  function automatic deq_pkg::deq_req_t mk(logic [deq_pkg::REQ_W-1:0] req,
                                           logic [deq_pkg::VAL_W-1:0] first,
                                           logic [deq_pkg::STEP_W-1:0] stride,
                                           logic [deq_pkg::VAL_W-1:0] last,
                                           logic [deq_pkg::DROP_W-1:0] drop,
                                           logic [deq_pkg::POS_W-1:0] pos);
    deq_pkg::deq_req_t r;
    r.req_type   = req;
    r.run_start  = first;
    r.run_step   = stride;
    r.run_end    = last;
    r.drop_count = drop;
    r.position   = pos;
    return r;
  endfunction

  // Append one request to the directed list
  task automatic add_directed(deq_pkg::deq_req_t r);
    directed_reqs.insert(directed_reqs.size(), r);
  endtask

  // Mostly well-formed requests with random content, the rest fully random
  function automatic deq_pkg::deq_req_t random_request();
    deq_pkg::deq_req_t r;
    int                pick;
    int                len;
    longint            first;
    longint            stride;
    longint            last;
    r.req_type   = deq_pkg::REQ_W'($urandom_range(0, 7));
    r.run_start  = $urandom;
    r.run_step   = deq_pkg::STEP_W'($urandom >> 1);
    r.run_end    = $urandom;
    r.drop_count = deq_pkg::DROP_W'($urandom_range(0, 65535));
    r.position   = deq_pkg::POS_W'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.req_type = ($urandom_range(0, 1) == 0) ? deq_pkg::REQ_ADD_FRONT
                                                : deq_pkg::REQ_ADD_BACK;
      if ($urandom_range(0, 3) == 0) first = longint'($signed($urandom));
      else first = longint'($urandom_range(0, 2000)) - 1000;
      case ($urandom_range(0, 29))
        0:       stride = 0;
        1, 2, 3: stride = longint'($urandom >> 1);
        default: stride = longint'($urandom_range(1, 16));
      endcase
      len  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 6);
      last = (len == 0) ? first - 1 : first + stride * (len - 1);
      if (last > VAL_MAX) last = VAL_MAX;
      if (last < VAL_MIN) last = VAL_MIN;
      r.run_start = first[deq_pkg::VAL_W-1:0];
      r.run_step  = stride[deq_pkg::STEP_W-1:0];
      r.run_end   = last[deq_pkg::VAL_W-1:0];
    end else if (pick < 60) begin
      r.req_type = ($urandom_range(0, 1) == 0) ? deq_pkg::REQ_DROP_FRONT
                                                : deq_pkg::REQ_DROP_BACK;
      if ($urandom_range(0, 7) != 0) r.drop_count = deq_pkg::DROP_W'($urandom_range(0, 10));
    end else if (pick < 78) begin
      r.req_type = deq_pkg::REQ_GET;
      if ($urandom_range(0, 2) != 0) r.position = deq_pkg::POS_W'($urandom_range(0, 12));
    end else if (pick < 86) begin
      r.req_type = deq_pkg::REQ_DUMP;
    end
    return r;
  endfunction

  // Hold the request until accepted, then idle for the given gap
  task automatic send_request(deq_pkg::deq_req_t r, int gap);
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every expected result has come back, with a bound
  task automatic wait_for_results();
    int guard;
    guard = 0;
    @(posedge clk);
    while (pending != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    // Empty store, then a small ring with front wrap, then the value extremes,
    // a zero-step run to full, a full dump and the spare codes
    add_directed(mk(deq_pkg::REQ_DUMP, 0, 0, 0, 0, 0));
    add_directed(mk(deq_pkg::REQ_GET, 0, 0, 0, 0, 0));
    add_directed(mk(deq_pkg::REQ_DROP_FRONT, 0, 0, 0, 5, 0));
    add_directed(mk(deq_pkg::REQ_ADD_BACK, 1, 1, 5, 0, 0));
    add_directed(mk(deq_pkg::REQ_ADD_FRONT, 10, 10, 30, 0, 0));
    add_directed(mk(deq_pkg::REQ_ADD_BACK, 7, 1, 3, 0, 0));
    add_directed(mk(deq_pkg::REQ_GET, 0, 0, 0, 0, 0));
    add_directed(mk(deq_pkg::REQ_GET, 0, 0, 0, 0, 7));
    add_directed(mk(deq_pkg::REQ_GET, 0, 0, 0, 0, 8));
    add_directed(mk(deq_pkg::REQ_DUMP, 0, 0, 0, 0, 0));
    add_directed(mk(deq_pkg::REQ_DROP_BACK, 0, 0, 0, 2, 0));
    add_directed(mk(deq_pkg::REQ_DROP_FRONT, 0, 0, 0, 6, 0));
    add_directed(mk(deq_pkg::REQ_ADD_BACK, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                    0, 0));
    add_directed(mk(deq_pkg::REQ_ADD_FRONT, 32'h7FFF_FFF0, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                    0, 0));
    add_directed(mk(deq_pkg::REQ_ADD_BACK, 32'h8000_0000, 5, 32'h8000_0000, 0, 0));
    add_directed(mk(deq_pkg::REQ_ADD_BACK, 42, 0, 42, 0, 0));
    add_directed(mk(deq_pkg::REQ_ADD_FRONT, 1, 1, 3, 0, 0));
    add_directed(mk(deq_pkg::REQ_GET, 0, 0, 0, 0, 63));
    add_directed(mk(deq_pkg::REQ_DUMP, 0, 0, 0, 0, 0));
    add_directed(mk(REQ_SPARE_LO, 0, 0, 0, 0, 0));
    add_directed(mk(REQ_SPARE_HI, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                    16'hFFFF, 6'h3F));
    add_directed(mk(deq_pkg::REQ_DROP_FRONT, 0, 0, 0, 16'hFFFF, 0));
    add_directed(mk(deq_pkg::REQ_ADD_FRONT, -3, 0, -3, 0, 0));
    add_directed(mk(deq_pkg::REQ_DROP_BACK, 0, 0, 0, 16'hFFFF, 0));

    // Hold reset, then release
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_reqs[i]) send_request(directed_reqs[i], sender_gap());
    in_valid <= 1'b0;
    wait_for_results();

    // Random traffic, draining the block completely now and then
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      send_request(random_request(), sender_gap());
      if (i % 150 == 149) begin
        in_valid <= 1'b0;
        wait_for_results();
      end
    end
    in_valid <= 1'b0;
    wait_for_results();
    repeat (20) @(posedge clk);

    $display("covered %0d requests (directed corner cases plus random runs, drops, gets,",
             requests_seen);
    $display("dumps and spare codes) and checked %0d results", results_seen);
    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("double_ended_queue_engine regression: pass");
    end else begin
      $display("double_ended_queue_engine regression: fail");
    end
    $finish;
  end

  // Generous bound: every request a full 64-element dump under long stalls, several times over
  initial begin
    #(64'd100_000_000);
    $display("%0t: run did not finish in time", $time);
    $display("double_ended_queue_engine regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/deq_pkg.sv
hw/rtl/deq_store.sv
hw/rtl/double_ended_queue_engine.sv
verif/deq_checker.sv
verif/tb.sv
